### design/etfe_pkg.sv
// ============================================================================
// Escape-time fractal engine package
// Shared widths, register indexes, fractal kind codes, reset values and the
// job record that travels from the front end to the iteration unit.
// ============================================================================
package etfe_pkg;

    // Default values of the top-level parameters.
    localparam int FRAC_BITS_DEF  = 28;
    localparam int ITER_WIDTH_DEF = 12;

    // Fixed field widths.
    localparam int Z_W         = 32;
    localparam int RADIUS_W    = 36;
    localparam int COLOR_W     = 24;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int IN_DATA_W   = 2 * Z_W;
    localparam int QUEUE_DEPTH = 2;

    // Fractal kind codes; the unused code behaves as Mandelbrot.
    localparam logic [KIND_W-1:0] KIND_MANDELBROT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JULIA      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MANDELBAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd6;

    // Reset values of the configuration registers.
    localparam int                  MAX_ITER_RST = 100;
    localparam logic [RADIUS_W-1:0] RADIUS_RST   = 36'd1073741824;
    localparam logic [COLOR_W-1:0]  HIGH_RST     = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]  BASE_RST     = 24'h000000;

    // One classified point: starting z, constant c and the conjugate flag.
    typedef struct packed {
        logic signed [Z_W-1:0] zx;
        logic signed [Z_W-1:0] zy;
        logic signed [Z_W-1:0] cx;
        logic signed [Z_W-1:0] cy;
        logic                  bar;
    } t_job;

    // Outcome flags handed from the iteration unit to the colour unit.
    typedef struct packed {
        logic escaped;
        logic bar;
    } t_esc_flags;

endpackage

### design/etfe_front.sv
// ============================================================================
// Escape-time fractal engine front end
// Holds the configuration registers and turns each incoming point into a job
// with its starting z and constant c, chosen by the fractal kind.
// ============================================================================
module etfe_front #(
    parameter int ITER_WIDTH = etfe_pkg::ITER_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [etfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [etfe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    input  logic [etfe_pkg::IN_DATA_W-1:0]     i_in_data,
    output logic                               o_push,
    output etfe_pkg::t_job                     o_job,
    output logic [ITER_WIDTH-1:0]              o_max_iter,
    output logic [etfe_pkg::RADIUS_W-1:0]      o_radius_sq,
    output logic [etfe_pkg::COLOR_W-1:0]       o_high_color,
    output logic [etfe_pkg::COLOR_W-1:0]       o_base_color
);
    import etfe_pkg::*;

    logic [KIND_W-1:0]     r_kind;
    logic [ITER_WIDTH-1:0] r_max_iter;
    logic [RADIUS_W-1:0]   r_radius_sq;
    logic signed [Z_W-1:0] r_julia_re;
    logic signed [Z_W-1:0] r_julia_im;
    logic [COLOR_W-1:0]    r_high;
    logic [COLOR_W-1:0]    r_base;
    logic signed [Z_W-1:0] w_pre;
    logic signed [Z_W-1:0] w_pim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_MANDELBROT;
            r_max_iter  <= ITER_WIDTH'(MAX_ITER_RST);
            r_radius_sq <= RADIUS_RST;
            r_julia_re  <= '0;
            r_julia_im  <= '0;
            r_high      <= HIGH_RST;
            r_base      <= BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KIND:     r_kind      <= i_cfg_data[KIND_W-1:0];
                REG_MAX_ITER: r_max_iter  <= i_cfg_data[ITER_WIDTH-1:0];
                REG_RADIUS:   r_radius_sq <= i_cfg_data[RADIUS_W-1:0];
                REG_JULIA_RE: r_julia_re  <= i_cfg_data[Z_W-1:0];
                REG_JULIA_IM: r_julia_im  <= i_cfg_data[Z_W-1:0];
                REG_HIGH:     r_high      <= i_cfg_data[COLOR_W-1:0];
                REG_BASE:     r_base      <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_pre = i_in_data[Z_W-1:0];
    assign w_pim = i_in_data[2*Z_W-1:Z_W];

    // Julia starts from the point itself; the other kinds start from zero
    // and use the point as the constant.
    always_comb begin
        o_job.bar = 1'b0;
        case (r_kind)
            KIND_JULIA: begin
                o_job.zx = w_pre;
                o_job.zy = w_pim;
                o_job.cx = r_julia_re;
                o_job.cy = r_julia_im;
            end
            KIND_MANDELBAR: begin
                o_job.zx  = '0;
                o_job.zy  = '0;
                o_job.cx  = w_pre;
                o_job.cy  = w_pim;
                o_job.bar = 1'b1;
            end
            KIND_MANDELBROT: begin
                o_job.zx = '0;
                o_job.zy = '0;
                o_job.cx = w_pre;
                o_job.cy = w_pim;
            end
            default: begin
                o_job.zx = '0;
                o_job.zy = '0;
                o_job.cx = w_pre;
                o_job.cy = w_pim;
            end
        endcase
    end

    assign o_push       = i_in_valid;
    assign o_max_iter   = r_max_iter;
    assign o_radius_sq  = r_radius_sq;
    assign o_high_color = r_high;
    assign o_base_color = r_base;

endmodule

### design/etfe_queue.sv
// ============================================================================
// Escape-time fractal engine job queue
// Short register queue that decouples the front end from the iteration unit.
// ============================================================================
module etfe_queue #(
    parameter int DEPTH = etfe_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  etfe_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output etfe_pkg::t_job o_data
);
    import etfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/etfe_iter.sv
// ============================================================================
// Escape-time fractal engine iteration unit
// Runs z = z^2 + c (or its conjugate) step by step: state I_MUL forms the
// three products, then state I_UPD checks the magnitude and forms the new z.
// ============================================================================
module etfe_iter #(
    parameter int FRAC_BITS  = etfe_pkg::FRAC_BITS_DEF,
    parameter int ITER_WIDTH = etfe_pkg::ITER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_empty,
    output logic                          o_job_pop,
    input  etfe_pkg::t_job                i_job,
    input  logic [ITER_WIDTH-1:0]         i_max_iter,
    input  logic [etfe_pkg::RADIUS_W-1:0] i_radius_sq,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [ITER_WIDTH-1:0]         o_step,
    output etfe_pkg::t_esc_flags          o_flags
);
    import etfe_pkg::*;

    localparam int PROD_W = 2 * Z_W;
    localparam int THR_W  = RADIUS_W + FRAC_BITS;
    localparam int CMP_W  = (THR_W > PROD_W + 1) ? THR_W : PROD_W + 1;

    typedef enum logic [3:0] {
        I_IDLE = 4'b0001,
        I_MUL  = 4'b0010,
        I_UPD  = 4'b0100,
        I_DONE = 4'b1000
    } t_iter_state;

    t_iter_state              r_state;
    t_iter_state              n_state;
    logic signed [Z_W-1:0]    r_zx;
    logic signed [Z_W-1:0]    r_zy;
    logic signed [Z_W-1:0]    r_cx;
    logic signed [Z_W-1:0]    r_cy;
    logic                     r_bar;
    logic signed [PROD_W-1:0] r_sx;
    logic signed [PROD_W-1:0] r_sy;
    logic signed [PROD_W-1:0] r_p;
    logic [ITER_WIDTH-1:0]    r_i;
    logic [ITER_WIDTH-1:0]    r_step;
    logic                     r_escaped;

    logic signed [PROD_W:0]   w_diff;
    logic signed [PROD_W:0]   w_re;
    logic signed [PROD_W-1:0] w_im0;
    logic signed [PROD_W:0]   w_im;
    logic signed [PROD_W+1:0] w_nx;
    logic signed [PROD_W+1:0] w_ny;
    logic signed [Z_W-1:0]    w_nx_sat;
    logic signed [Z_W-1:0]    w_ny_sat;
    logic [PROD_W:0]          w_mag;
    logic [CMP_W-1:0]         w_thr;
    logic                     w_escape;
    logic                     w_last;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W+1:0] v);
        logic hi_same;
        hi_same = (v[PROD_W+1:Z_W-1] == '0) || (v[PROD_W+1:Z_W-1] == '1);
        if (hi_same) begin
            return v[Z_W-1:0];
        end else if (v[PROD_W+1]) begin
            return {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Z_W-1){1'b1}}};
        end
    endfunction

    // New z from the registered products, scaled back with floor rounding.
    assign w_diff   = {r_sx[PROD_W-1], r_sx} - {r_sy[PROD_W-1], r_sy};
    assign w_re     = w_diff >>> FRAC_BITS;
    assign w_im0    = r_p >>> (FRAC_BITS - 1);
    assign w_im     = r_bar ? -{w_im0[PROD_W-1], w_im0} : {w_im0[PROD_W-1], w_im0};
    assign w_nx     = {w_re[PROD_W], w_re} + {{(PROD_W + 2 - Z_W){r_cx[Z_W-1]}}, r_cx};
    assign w_ny     = {w_im[PROD_W], w_im} + {{(PROD_W + 2 - Z_W){r_cy[Z_W-1]}}, r_cy};
    assign w_nx_sat = sat_z(w_nx);
    assign w_ny_sat = sat_z(w_ny);

    // The squares of the current z double as its exact magnitude.
    assign w_mag    = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_thr    = CMP_W'(i_radius_sq) << FRAC_BITS;
    assign w_escape = (r_i != '0) && (CMP_W'(w_mag) > w_thr);
    assign w_last   = (r_i == i_max_iter);

    always_comb begin
        n_state = r_state;
        case (r_state)
            I_IDLE: begin
                if (!i_job_empty) begin
                    n_state = I_MUL;
                end
            end
            I_MUL: n_state = I_UPD;
            I_UPD: begin
                if (w_escape || w_last) begin
                    n_state = I_DONE;
                end else begin
                    n_state = I_MUL;
                end
            end
            I_DONE: begin
                if (i_res_ready) begin
                    n_state = I_IDLE;
                end
            end
            default: n_state = I_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= I_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            I_IDLE: begin
                r_zx  <= i_job.zx;
                r_zy  <= i_job.zy;
                r_cx  <= i_job.cx;
                r_cy  <= i_job.cy;
                r_bar <= i_job.bar;
                r_i   <= '0;
            end
            I_MUL: begin
                r_sx <= r_zx * r_zx;
                r_sy <= r_zy * r_zy;
                r_p  <= r_zx * r_zy;
            end
            I_UPD: begin
                if (w_escape) begin
                    r_step    <= r_i - 1'b1;
                    r_escaped <= 1'b1;
                end else if (w_last) begin
                    r_step    <= r_i;
                    r_escaped <= 1'b0;
                end else begin
                    r_zx <= w_nx_sat;
                    r_zy <= w_ny_sat;
                    r_i  <= r_i + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_job_pop       = (r_state == I_IDLE) && !i_job_empty;
    assign o_res_valid     = (r_state == I_DONE);
    assign o_step          = r_step;
    assign o_flags.escaped = r_escaped;
    assign o_flags.bar     = r_bar;

endmodule

### design/etfe_color.sv
// ============================================================================
// Escape-time fractal engine colour unit
// Maps the escape step linearly between the two colour words with a
// bit-serial restoring divider, and holds the result in the output register.
// ============================================================================
module etfe_color #(
    parameter int ITER_WIDTH = etfe_pkg::ITER_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_res_valid,
    output logic                         o_res_ready,
    input  logic [ITER_WIDTH-1:0]        i_step,
    input  etfe_pkg::t_esc_flags         i_flags,
    input  logic [ITER_WIDTH-1:0]        i_max_iter,
    input  logic [etfe_pkg::COLOR_W-1:0] i_high_color,
    input  logic [etfe_pkg::COLOR_W-1:0] i_base_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [etfe_pkg::COLOR_W-1:0] o_out_color,
    output logic [ITER_WIDTH-1:0]        o_out_step,
    output logic                         o_out_escaped
);
    import etfe_pkg::*;

    localparam int DW    = COLOR_W + ITER_WIDTH;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MUL  = 4'b0010,
        C_DIV  = 4'b0100,
        C_WB   = 4'b1000
    } t_color_state;

    t_color_state           r_state;
    t_color_state           n_state;
    logic                   r_neg;
    logic [COLOR_W-1:0]     r_span_mag;
    logic [ITER_WIDTH-1:0]  r_k;
    logic [ITER_WIDTH-1:0]  r_step;
    logic                   r_escaped;
    logic [DW-1:0]          r_dvd;
    logic [ITER_WIDTH-1:0]  r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [COLOR_W-1:0]     r_out_color;
    logic [ITER_WIDTH-1:0]  r_out_step;
    logic                   r_out_escaped;

    logic signed [COLOR_W:0] w_span;
    logic [COLOR_W:0]        w_span_abs;
    logic [ITER_WIDTH:0]     w_trial;
    logic                    w_ge;
    logic [ITER_WIDTH:0]     w_sub;
    logic [COLOR_W-1:0]      w_mix;
    logic                    w_accept;
    logic                    w_load;

    assign w_span     = {1'b0, i_high_color} - {1'b0, i_base_color};
    assign w_span_abs = w_span[COLOR_W] ? -w_span : w_span;

    // One quotient bit per cycle; the quotient fills the dividend register.
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_max_iter});
    assign w_sub   = w_trial - {1'b0, i_max_iter};

    assign w_mix = r_neg ? i_base_color - r_dvd[COLOR_W-1:0]
                         : i_base_color + r_dvd[COLOR_W-1:0];

    assign o_res_ready = (r_state == C_IDLE);
    assign w_accept    = i_res_valid && o_res_ready;
    assign w_load      = (r_state == C_WB) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_res_valid) begin
                    n_state = i_flags.escaped ? C_MUL : C_WB;
                end
            end
            C_MUL: n_state = C_DIV;
            C_DIV: begin
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_state = C_WB;
                end
            end
            C_WB: begin
                if (w_load) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg      <= w_span[COLOR_W];
            r_span_mag <= w_span_abs[COLOR_W-1:0];
            r_k        <= i_flags.bar ? i_step : i_max_iter - i_step;
            r_step     <= i_step;
            r_escaped  <= i_flags.escaped;
        end
        case (r_state)
            C_MUL: begin
                r_dvd <= r_span_mag * r_k;
                r_rem <= '0;
                r_cnt <= '0;
            end
            C_DIV: begin
                r_rem <= w_ge ? w_sub[ITER_WIDTH-1:0] : w_trial[ITER_WIDTH-1:0];
                r_dvd <= {r_dvd[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out_color   <= r_escaped ? w_mix : i_high_color;
            r_out_step    <= r_step;
            r_out_escaped <= r_escaped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_color   = r_out_color;
    assign o_out_step    = r_out_step;
    assign o_out_escaped = r_out_escaped;

endmodule

### design/escape_time_fractal_engine.sv
// ============================================================================
// Escape-time fractal engine, top level
// Mandelbrot, Julia and Mandelbar escape-time iteration with linear coloring.
// ============================================================================
// The queue takes a point whenever it has room. The iteration unit works on
// one point at a time and hands its result on only while the color unit is
// idle; it then starts the next point while the color unit divides and waits
// for the output register to come free.
// Reset: synchronous active-low i_rst_n empties the queue, idles both units,
// drops m_axis_tvalid and loads the register defaults.
// ============================================================================
module escape_time_fractal_engine #(
    parameter int FRAC_BITS  = etfe_pkg::FRAC_BITS_DEF,
    parameter int ITER_WIDTH = etfe_pkg::ITER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel: i_cfg_index selects the register.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [etfe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [etfe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Point input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [etfe_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // point_re, point_im
    // Pixel output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((etfe_pkg::COLOR_W + ITER_WIDTH + 7) / 8) * 8 - 1:0]
                                              m_axis_tdata,   // pixel_color, escape_step
    output logic                              m_axis_tuser    // escaped
);
    import etfe_pkg::*;

    localparam int OUT_W       = COLOR_W + ITER_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // The front end classifies each point into a job (start z, constant c
    // and conjugate flag); a point transfer happens whenever the queue has
    // room, so the front never waits on the iteration unit directly.
    logic                  w_push;
    t_job                  w_front_job;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_pop;
    t_job                  w_queue_job;
    logic [ITER_WIDTH-1:0] w_max_iter;
    logic [RADIUS_W-1:0]   w_radius_sq;
    logic [COLOR_W-1:0]    w_high;
    logic [COLOR_W-1:0]    w_base;

    // Hand-off from the iteration unit to the color unit.
    logic                  w_res_valid;
    logic                  w_res_ready;
    logic [ITER_WIDTH-1:0] w_res_step;
    t_esc_flags            w_res_flags;

    logic [COLOR_W-1:0]    w_out_color;
    logic [ITER_WIDTH-1:0] w_out_step;

    assign s_axis_tready = !w_full;

    etfe_front #(
        .ITER_WIDTH (ITER_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_data    (s_axis_tdata),
        .o_push       (w_push),
        .o_job        (w_front_job),
        .o_max_iter   (w_max_iter),
        .o_radius_sq  (w_radius_sq),
        .o_high_color (w_high),
        .o_base_color (w_base)
    );

    // Two-entry queue lets the front take new points while the back iterates.
    etfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_queue_job)
    );

    // Iteration unit: three 32x32 products per step, then the exact
    // magnitude test against the squared radius and the saturated update.
    etfe_iter #(
        .FRAC_BITS  (FRAC_BITS),
        .ITER_WIDTH (ITER_WIDTH)
    ) u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_empty),
        .o_job_pop   (w_pop),
        .i_job       (w_queue_job),
        .i_max_iter  (w_max_iter),
        .i_radius_sq (w_radius_sq),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_step      (w_res_step),
        .o_flags     (w_res_flags)
    );

    // Color unit: interpolates between base and high color for escaped
    // points and owns the output register, so the iteration unit can start
    // the next point while a finished pixel waits for its transfer.
    etfe_color #(
        .ITER_WIDTH (ITER_WIDTH)
    ) u_color (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (w_res_valid),
        .o_res_ready   (w_res_ready),
        .i_step        (w_res_step),
        .i_flags       (w_res_flags),
        .i_max_iter    (w_max_iter),
        .i_high_color  (w_high),
        .i_base_color  (w_base),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_color   (w_out_color),
        .o_out_step    (w_out_step),
        .o_out_escaped (m_axis_tuser)
    );

    // Pixel color in the low bits, escape step above it, zero padding on top.
    assign m_axis_tdata = OUT_TDATA_W'({w_out_step, w_out_color});

endmodule

### dv/testbench.sv
// ============================================================================
// Escape-time fractal engine regression
// Sends points to the engine over the input stream and checks every pixel
// transfer against a cycle-free prediction of the escape iteration and the
// linear colour map. Directed points cover the field extremes, every fractal
// kind, the register masks and the corner cases. A long random part then
// follows under changing register settings and stream pacing.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import etfe_pkg::*;

    // One in Q4.28.
    localparam int ONE = 1 << 28;
    // Index past the end of the register file; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    // Kind code that has no mode of its own and must behave as Mandelbrot.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // Useful radii in unsigned Q8.28.
    localparam logic [RADIUS_W-1:0] RADIUS_ONE  = 36'h0_1000_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_FOUR = 36'h0_4000_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX  = 36'hF_FFFF_FFFF;
    // Cycles without any transfer before the run is declared hung. The slowest
    // single point is one that never escapes under limit 4095.
    localparam int STALL_LIMIT = 50000;
    // Random part: register settings and points per setting.
    localparam int RANDOM_SETTINGS  = 28;
    localparam int POINTS_PER_SETTING = 62;

    // Stream pacing: how often the point source idles and the pixel sink stalls.
    typedef enum {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    // Everything one pixel transfer carries.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [11:0]        step;
        logic               escaped;
    } pixel_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // point_re, point_im

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;                 // pixel_color, escape_step
    logic        m_axis_tuser;                 // escaped

    // Copy of the register file as the engine should hold it.
    logic [KIND_W-1:0]     cfg_kind     = KIND_MANDELBROT;
    logic [11:0]           cfg_max_iter = 12'(MAX_ITER_RST);
    logic [RADIUS_W-1:0]   cfg_radius   = RADIUS_RST;
    logic signed [Z_W-1:0] cfg_julia_re = '0;
    logic signed [Z_W-1:0] cfg_julia_im = '0;
    logic [COLOR_W-1:0]    cfg_high     = HIGH_RST;
    logic [COLOR_W-1:0]    cfg_base     = BASE_RST;

    // Pixels predicted for accepted points, oldest first.
    pixel_t pending_pixels[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    escape_time_fractal_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic longint clamp_q428(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -(64'sd2147483648)) begin
            return -(64'sd2147483648);
        end
        return v;
    endfunction

    // Runs the escape iteration for one point under the current registers and
    // maps the escape step onto the colour range.
    function automatic pixel_t escape_pixel(input logic signed [Z_W-1:0] pre,
                                            input logic signed [Z_W-1:0] pim);
        longint      zx, zy, cx, cy, re, im, span, weight, shade;
        logic [63:0] mag;
        bit          julia, bar;
        int unsigned n;
        pixel_t      px;
        julia = (cfg_kind == KIND_JULIA);
        bar   = (cfg_kind == KIND_MANDELBAR);
        if (julia) begin
            zx = pre;
            zy = pim;
            cx = cfg_julia_re;
            cy = cfg_julia_im;
        end else begin
            zx = 0;
            zy = 0;
            cx = pre;
            cy = pim;
        end
        n = cfg_max_iter;
        px.color   = cfg_high;
        px.step    = cfg_max_iter;
        px.escaped = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
            // The products are exact Q8.56; the shifts round toward minus
            // infinity, and the doubled cross product saves one shift bit.
            re = (zx * zx - zy * zy) >>> FRAC_BITS_DEF;
            im = (zx * zy) >>> (FRAC_BITS_DEF - 1);
            if (bar) begin
                im = -im;
            end
            zx  = clamp_q428(re + cx);
            zy  = clamp_q428(im + cy);
            mag = zx * zx + zy * zy;
            // Exact comparison: any fraction bit above an equal integer part
            // already counts as outside the radius.
            if (mag[63:28] > cfg_radius || (mag[63:28] == cfg_radius && mag[27:0] != 0)) begin
                span   = longint'(cfg_high) - longint'(cfg_base);
                weight = bar ? longint'(i) : longint'(n - i);
                shade  = longint'(cfg_base) + (span * weight) / longint'(n);
                px.color   = shade[COLOR_W-1:0];
                px.step    = 12'(i);
                px.escaped = 1'b1;
                break;
            end
        end
        return px;
    endfunction

    // Mirrors a register write, with the same masking as the hardware.
    function automatic void note_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KIND:     cfg_kind = data[KIND_W-1:0];
            REG_MAX_ITER: cfg_max_iter = data[11:0];
            REG_RADIUS:   cfg_radius = data[RADIUS_W-1:0];
            REG_JULIA_RE: cfg_julia_re = data[Z_W-1:0];
            REG_JULIA_IM: cfg_julia_im = data[Z_W-1:0];
            REG_HIGH:     cfg_high = data[COLOR_W-1:0];
            REG_BASE:     cfg_base = data[COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_GAPS: begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default: begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endfunction

    // One register write transfer. The valid drops for a cycle afterwards so
    // that back-to-back writes never lower and raise it in the same step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        note_register_write(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One point transfer, after an optional random gap. The valid stays high
    // when the next point follows without a gap.
    task automatic send_point(input logic [Z_W-1:0] pre, input logic [Z_W-1:0] pim);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pim, pre};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(escape_pixel(pre, pim));
    endtask

    // Stops the point stream and waits for every predicted pixel, so that the
    // registers may be written safely afterwards.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // A coordinate: mostly inside the interesting +-2.5 window, sometimes a
    // full 32-bit value or one of the range corners.
    function automatic logic [Z_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'(int'($urandom_range(0, 32'd1342177280)) - 671088640);
        endcase
    endfunction

    // Writes every register with a fresh random setting. Limits stay small so
    // that never-escaping points do not dominate the run time.
    task automatic randomize_registers(input int setting);
        logic [KIND_W-1:0]     kind;
        logic [CFG_DATA_W-1:0] limit, radius, jre, jim, high, base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = KIND_MANDELBROT;
            4, 5, 6:    kind = KIND_JULIA;
            7, 8:       kind = KIND_MANDELBAR;
            default:    kind = KIND_UNUSED;
        endcase
        case (setting % 7)
            0:       limit = 36'd1;
            1:       limit = 36'd255;
            default: limit = 36'($urandom_range(2, 40));
        endcase
        case ($urandom_range(0, 7))
            0:       radius = '0;
            1:       radius = RADIUS_MAX;
            2:       radius = {4'($urandom_range(0, 15)), 32'($urandom)};
            3:       radius = RADIUS_ONE;
            default: radius = RADIUS_FOUR + 36'($urandom_range(0, 32'd3221225472));
        endcase
        if ($urandom_range(0, 9) < 7) begin
            jre = 36'(32'(int'($urandom_range(0, 2 * ONE)) - ONE));
            jim = 36'(32'(int'($urandom_range(0, 2 * ONE)) - ONE));
        end else begin
            jre = {4'($urandom_range(0, 15)), 32'($urandom)};
            jim = {4'($urandom_range(0, 15)), 32'($urandom)};
        end
        high = 36'($urandom_range(0, 24'hFF_FFFF));
        base = ($urandom_range(0, 5) == 0) ? '0 : 36'($urandom_range(0, 24'hFF_FFFF));
        write_register(REG_KIND, 36'(kind));
        write_register(REG_MAX_ITER, limit);
        write_register(REG_RADIUS, radius);
        write_register(REG_JULIA_RE, jre);
        write_register(REG_JULIA_IM, jim);
        write_register(REG_HIGH, high);
        write_register(REG_BASE, base);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Register defaults after reset: Mandelbrot, limit 100, radius 4.0, white
    // over black. Covers the origin, a slowly converging interior point, an
    // immediate escape and both corners of the coordinate range.
    task automatic test_reset_defaults();
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'(ONE / 4), 32'h0000_0000);
        send_point(32'(2 * ONE), 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        drain_pixels();
    endtask

    // Each register is written with junk above its width; the unused index is
    // written too and must leave everything as it was. A descending colour
    // range checks the signed interpolation.
    task automatic test_register_fields();
        write_register(REG_KIND, 36'hF_FFFF_FFF9);
        write_register(REG_MAX_ITER, 36'hF_FFFF_F010);
        write_register(REG_RADIUS, RADIUS_MAX);
        write_register(REG_JULIA_RE, 36'hF_C000_0000);
        write_register(REG_JULIA_IM, 36'hA_0800_0000);
        write_register(REG_HIGH, 36'hF_FF12_3456);
        write_register(REG_BASE, 36'hF_FFAB_CDEF);
        write_register(REG_NONE, 36'h0_0000_0001);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'(ONE), 32'(-ONE));
        drain_pixels();
        write_register(REG_RADIUS, RADIUS_FOUR);
        send_point(32'(ONE / 2), 32'(ONE / 3));
        send_point(32'(-ONE), 32'(ONE / 8));
        drain_pixels();
    endtask

    // The same two points under every kind code, the unused one included.
    task automatic test_fractal_kinds();
        logic [KIND_W-1:0] kinds [4];
        kinds = '{KIND_MANDELBROT, KIND_JULIA, KIND_MANDELBAR, KIND_UNUSED};
        write_register(REG_MAX_ITER, 36'd32);
        write_register(REG_RADIUS, RADIUS_FOUR);
        write_register(REG_JULIA_RE, 36'(32'(-(ONE * 4 / 5))));
        write_register(REG_JULIA_IM, 36'(32'(ONE / 6)));
        write_register(REG_HIGH, 36'h0_00FF_8000);
        write_register(REG_BASE, 36'h0_0000_00FF);
        foreach (kinds[k]) begin
            write_register(REG_KIND, 36'(kinds[k]));
            send_point(32'(-(ONE * 3 / 4)), 32'(ONE / 10));
            send_point(32'(ONE * 3 / 10), 32'(ONE / 2));
            drain_pixels();
        end
    endtask

    // A limit of zero runs no step at all, whatever the point.
    task automatic test_zero_limit();
        write_register(REG_MAX_ITER, 36'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain_pixels();
    endtask

    // Extreme starting values and constants push both components into
    // saturation. The last radius equals the largest possible integer part
    // of the magnitude with no fraction, which must not count as escaping.
    task automatic test_component_saturation();
        write_register(REG_KIND, 36'(KIND_JULIA));
        write_register(REG_MAX_ITER, 36'd6);
        write_register(REG_RADIUS, RADIUS_MAX);
        write_register(REG_JULIA_RE, 36'h0_8000_0000);
        write_register(REG_JULIA_IM, 36'h0_7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        drain_pixels();
        write_register(REG_KIND, 36'(KIND_MANDELBAR));
        write_register(REG_RADIUS, 36'h8_0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        drain_pixels();
    endtask

    // The largest limit: one interior point that runs every step, and quick
    // escapes whose colour divides by the full limit.
    task automatic test_longest_limit();
        write_register(REG_KIND, 36'(KIND_MANDELBROT));
        write_register(REG_MAX_ITER, 36'd4095);
        write_register(REG_RADIUS, RADIUS_FOUR);
        write_register(REG_HIGH, 36'h0_FFFF_FFFF);
        write_register(REG_BASE, 36'h0_0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'(ONE / 2), 32'(ONE / 2));
        drain_pixels();
        write_register(REG_KIND, 36'(KIND_MANDELBAR));
        send_point(32'(ONE / 2), 32'(ONE / 2));
        drain_pixels();
    endtask

    // Random points under a sequence of random settings. The pacing rotates so
    // that gaps and stalls hit every phase of the iteration and the divider.
    task automatic test_random_regions();
        for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
            set_pace(pace_t'(setting % 4));
            randomize_registers(setting);
            repeat (POINTS_PER_SETTING) begin
                send_point(random_coord(), random_coord());
            end
            drain_pixels();
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel sink and checker
    // ------------------------------------------------------------------------

    // Every accepted pixel transfer is compared with the oldest prediction,
    // field by field. The ready is redrawn every cycle from the stall rate.
    always @(posedge i_clk) begin
        pixel_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t ns: unexpected pixel transfer, actual color %06h step %0d escaped %0b",
                             $time, m_axis_tdata[23:0], m_axis_tdata[35:24], m_axis_tuser);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_axis_tdata[23:0] !== want.color) begin
                        $display("%0t ns: pixel_color mismatch, expected %06h, actual %06h",
                                 $time, want.color, m_axis_tdata[23:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[35:24] !== want.step) begin
                        $display("%0t ns: escape_step mismatch, expected %0d, actual %0d",
                                 $time, want.step, m_axis_tdata[35:24]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.escaped) begin
                        $display("%0t ns: escaped mismatch, expected %0b, actual %0b",
                                 $time, want.escaped, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a long stretch without any transfer on any channel means the
    // engine has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("escape_time_fractal_engine regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_pace(PACE_FULL);
        test_reset_defaults();
        test_register_fields();
        test_fractal_kinds();
        test_zero_limit();
        test_component_saturation();
        test_longest_limit();
        test_random_regions();

        // Everything predicted has arrived; give a stray extra pixel the time
        // of one full point at the last limit to show up.
        repeat (2 * cfg_max_iter + 64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("escape_time_fractal_engine regression: pass");
        end else begin
            $display("escape_time_fractal_engine regression: fail");
        end
        $finish;
    end

endmodule
